/* hdl/picture_reorder_buffer_assert.svh */
// ----------------------------------------------------------------------------
// Picture reorder buffer assertion macros
// Shorthand for the clocked, reset-qualified checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef PICTURE_REORDER_BUFFER_ASSERT_SVH
`define PICTURE_REORDER_BUFFER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PRB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/prb_pkg.sv */
// ----------------------------------------------------------------------------
// Picture reorder buffer package
// Transaction types, sequencer states and fixed constants.
// ----------------------------------------------------------------------------
`default_nettype none

package prb_pkg;

  localparam int IDX_W    = 32;
  localparam int POC_W    = 32;
  localparam int MAXD_W   = 4;
  localparam int MAXD_CAP = 15;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic signed [POC_W-1:0] poc;
    logic                    is_idr;
  } in_item_t;

  typedef struct packed {
    logic        [IDX_W-1:0]  decode_index;
    logic        [IDX_W-1:0]  output_index;
    logic signed [IDX_W-1:0]  order_shift;
    logic        [MAXD_W-1:0] reorder_depth;
    logic                     last;
  } out_item_t;

  // One held picture as stored in the buffer memory.
  typedef struct packed {
    logic        [IDX_W-1:0] dec;
    logic signed [POC_W-1:0] poc;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_SHIFT,
    ST_ADD
  } state_t;

endpackage

`default_nettype wire

/* hdl/prb_ram.sv */
// ----------------------------------------------------------------------------
// Picture reorder buffer RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module prb_ram #(
  parameter  int WIDTH  = 64,
  parameter  int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

/* hdl/prb_min_unit.sv */
// ----------------------------------------------------------------------------
// Picture reorder buffer minimum tracker
// Shared signed compare unit that keeps the lowest POC seen during a scan.
// ----------------------------------------------------------------------------
`default_nettype none

module prb_min_unit
  import prb_pkg::*;
#(
  parameter  int DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic                    clk,
  input  wire logic                    cmp_en,
  input  wire logic                    cmp_first,
  input  wire logic [AW-1:0]           cand_pos,
  input  wire logic signed [POC_W-1:0] cand_poc,
  input  wire logic [IDX_W-1:0]        cand_dec,
  output logic      [AW-1:0]           best_pos,
  output logic      [IDX_W-1:0]        best_dec
);

  logic signed [POC_W-1:0] best_poc_r;
  logic [AW-1:0]           best_pos_r;
  logic [IDX_W-1:0]        best_dec_r;
  logic                    take;

  // Strictly lower wins, so the earliest position keeps a tie.
  assign take = cmp_first || (cand_poc < best_poc_r);

  always_ff @(posedge clk) begin
    if (cmp_en && take) begin
      best_poc_r <= cand_poc;
      best_pos_r <= cand_pos;
      best_dec_r <= cand_dec;
    end
  end

  assign best_pos = best_pos_r;
  assign best_dec = best_dec_r;

endmodule

`default_nettype wire

/* hdl/picture_reorder_buffer.sv */
// ----------------------------------------------------------------------------
// Picture reorder buffer
// Holds decoded pictures and bumps them out in picture order count order.
// ----------------------------------------------------------------------------
// Each input transaction either adds a decoded picture (optionally an IDR,
// which drains the buffer first) or flushes the buffer. Pictures are kept
// oldest first in a small RAM; a bump scans the held entries through one
// shared signed comparator, reports the lowest POC (earliest on ties) as one
// output transaction, then closes the gap by moving the later entries down
// one slot at a time. A bump runs the scan, then loads the result register
// (waiting while the previous result is still stalled), then shifts; no
// entry moves when the newest entry is the one bumped. A plain add writes
// the new picture, and an add that fills the buffer then bumps one picture.
// A drain repeats the bump for every held picture. The input is stalled
// for the whole item; the result register lets the next item start while
// the last result is still waiting to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "picture_reorder_buffer_assert.svh"

module picture_reorder_buffer
  import prb_pkg::*;
#(
  parameter  int DEPTH = 16,
  localparam int AW    = $clog2(DEPTH),
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam int PW = (AW > MAXD_W) ? AW : MAXD_W;
  localparam logic [CW-1:0] LAST_SLOT = CW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL      = CW'(DEPTH);
  localparam logic [CW-1:0] ONE       = CW'(1);

  state_t            state_r, state_nxt;
  in_item_t          item_r, item_nxt;
  logic              drain_r, drain_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [IDX_W-1:0]  next_dec_r, next_dec_nxt;
  logic [IDX_W-1:0]  next_out_r, next_out_nxt;
  logic [MAXD_W-1:0] max_depth_r, max_depth_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     wa_r, wa_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic          in_fire;
  logic          out_free;
  logic          ram_we;
  logic [AW-1:0] ram_wa;
  entry_t        ram_wd;
  logic [AW-1:0] ram_ra;
  entry_t        ram_rd;
  logic [$bits(entry_t)-1:0] ram_rd_bits;

  logic          cmp_en;
  logic          cmp_first;
  logic [AW-1:0] cand_pos;
  logic [AW-1:0] best_pos;
  logic [IDX_W-1:0] best_dec;

  logic [PW-1:0]     pos_ext;
  logic [MAXD_W-1:0] bump_depth;
  logic              scan_done;
  logic              shift_more;
  logic              need_drain;

  // --------------------------------------------------------------------------
  // Storage and the shared compare unit.
  // --------------------------------------------------------------------------
  prb_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_addr (ram_ra),
    .rd_data (ram_rd_bits)
  );

  assign ram_rd = entry_t'(ram_rd_bits);

  prb_min_unit #(
    .DEPTH (DEPTH)
  ) u_min (
    .clk       (clk),
    .cmp_en    (cmp_en),
    .cmp_first (cmp_first),
    .cand_pos  (cand_pos),
    .cand_poc  (ram_rd.poc),
    .cand_dec  (ram_rd.dec),
    .best_pos  (best_pos),
    .best_dec  (best_dec)
  );

  // --------------------------------------------------------------------------
  // Handshake and shared decode terms.
  // --------------------------------------------------------------------------
  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The scan has seen every entry once the counter reaches the fill level;
  // the compare for the last entry happens in that same cycle.
  assign scan_done  = (idx_r == fill_r);
  assign shift_more = (idx_r < fill_r);
  assign need_drain = (in_data.kind == KIND_FLUSH) || in_data.is_idr;

  // Running maximum of the bump position, saturated to the field width.
  assign pos_ext = PW'(best_pos);
  always_comb begin
    bump_depth = max_depth_r;
    if (pos_ext > PW'(max_depth_r)) begin
      if (pos_ext > PW'(MAXD_CAP)) begin
        bump_depth = MAXD_W'(MAXD_CAP);
      end else begin
        bump_depth = pos_ext[MAXD_W-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer next state.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (need_drain && (fill_r != '0)) begin
            state_nxt = ST_SCAN;
          end else if (in_data.kind == KIND_ADD) begin
            state_nxt = ST_ADD;
          end
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (!shift_more && !pend_r) begin
          if (drain_r && (fill_r != ONE)) begin
            state_nxt = ST_SCAN;
          end else if (drain_r && (item_r.kind == KIND_ADD)) begin
            state_nxt = ST_ADD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_ADD: begin
        if (fill_r >= LAST_SLOT) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer outputs and datapath updates.
  // --------------------------------------------------------------------------
  always_comb begin
    item_nxt      = item_r;
    drain_nxt     = drain_r;
    fill_nxt      = fill_r;
    next_dec_nxt  = next_dec_r;
    next_out_nxt  = next_out_r;
    max_depth_nxt = max_depth_r;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    wa_nxt        = wa_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_wa        = wa_r;
    ram_wd        = ram_rd;
    ram_ra        = idx_r[AW-1:0];
    cmp_en        = 1'b0;
    cmp_first     = 1'b0;
    cand_pos      = AW'(idx_r - ONE);

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          item_nxt  = in_data;
          drain_nxt = need_drain && (fill_r != '0);
          idx_nxt   = '0;
        end
      end
      ST_SCAN: begin
        // Address idx goes out now; the data of idx - 1 is compared.
        idx_nxt   = idx_r + ONE;
        cmp_en    = (idx_r != '0);
        cmp_first = (idx_r == ONE);
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.decode_index  = best_dec;
          out_data_nxt.output_index  = next_out_r;
          out_data_nxt.order_shift   = next_out_r - best_dec;
          out_data_nxt.reorder_depth = bump_depth;
          // A drain ends with its final bump; an add bumps at most once.
          out_data_nxt.last          = !drain_r || (fill_r == ONE);
          next_out_nxt               = next_out_r + 1'b1;
          max_depth_nxt              = bump_depth;
          idx_nxt                    = CW'(best_pos) + ONE;
        end
      end
      ST_SHIFT: begin
        // Read entry idx and write it one slot lower on the next cycle.
        if (shift_more) begin
          idx_nxt  = idx_r + ONE;
          pend_nxt = 1'b1;
          wa_nxt   = AW'(idx_r - ONE);
        end
        if (pend_r) begin
          ram_we = 1'b1;
        end
        if (!shift_more && !pend_r) begin
          fill_nxt = fill_r - ONE;
          idx_nxt  = '0;
          if (fill_r == ONE) begin
            drain_nxt = 1'b0;
          end
        end
      end
      ST_ADD: begin
        ram_we       = 1'b1;
        ram_wa       = fill_r[AW-1:0];
        ram_wd.dec   = next_dec_r;
        ram_wd.poc   = item_r.poc;
        fill_nxt     = fill_r + ONE;
        next_dec_nxt = next_dec_r + 1'b1;
        drain_nxt    = 1'b0;
        idx_nxt      = '0;
      end
      default: begin
        idx_nxt = '0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      drain_r     <= 1'b0;
      fill_r      <= '0;
      next_dec_r  <= '0;
      next_out_r  <= '0;
      max_depth_r <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      drain_r     <= drain_nxt;
      fill_r      <= fill_nxt;
      next_dec_r  <= next_dec_nxt;
      next_out_r  <= next_out_nxt;
      max_depth_r <= max_depth_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    wa_r       <= wa_nxt;
    out_data_r <= out_data_nxt;
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `PRB_ASSERT_IMPL(a_idle_room, state_r == ST_IDLE, fill_r < FULL, "buffer full while idle")
  `PRB_ASSERT_IMPL(a_emit_nonempty, state_r == ST_EMIT, fill_r != '0, "bump from empty buffer")
  `PRB_ASSERT_IMPL(a_write_in_range, ram_we, CW'(ram_wa) <= fill_r, "write beyond fill level")
  `PRB_ASSERT_IMPL(a_depth_mono, $past(rst_n), max_depth_r >= $past(max_depth_r), "depth shrank")

endmodule

`default_nettype wire
